@@ src/pareg_pkg.sv @@
// Shared constants, types and the CRC byte step for the pairing address registration block.
package pareg_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int CHECK_W = 8;
    localparam int OUT_W   = 9;
    localparam int BYTES   = ADDR_W / 8;
    localparam int BYTE_CNT_W = $clog2(BYTES + 1);

    // CRC-8 definition
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] CRC_INIT     = 8'h07;
    localparam logic [7:0] CRC_ZERO_SUB = 8'h08;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } pareg_state_t;

    // Search token walking down the cell row
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } token_t;

    // Lookup key, fill level and write strobe broadcast to every cell
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic              key_nonzero;
        logic [CNT_W-1:0]  count;
        logic              wr_en;
    } bcast_t;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/pareg_crc.sv @@
// Byte-serial CRC-8 over the device address, low byte first.
module pareg_crc
    import pareg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] addr,
    output logic [7:0]        crc,
    output logic              done
);

    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]            crc_reg, crc_next;
    logic [ADDR_W-1:0]     data_reg, data_next;

    // Load on start, then fold in one byte per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        data_next = data_reg;
        if (start)
        begin
            cnt_next  = BYTE_CNT_W'(BYTES);
            crc_next  = CRC_INIT;
            data_next = addr;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            crc_next  = crc_byte(crc_reg ^ data_reg[7:0]);
            data_next = data_reg >> 8;
        end
    end

    // Byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Running CRC and remaining address bytes
    always_ff @(posedge clk)
    begin
        crc_reg  <= crc_next;
        data_reg <= data_next;
    end

    // A zero CRC is reported as 8
    assign crc  = (crc_reg == 8'h00) ? CRC_ZERO_SUB : crc_reg;
    assign done = (cnt_reg == '0);

endmodule

@@ src/pareg_cell.sv @@
// One table slot: stores an address and checks the passing search token against it.
module pareg_cell
    import pareg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_index,
    input  bcast_t           bcast,
    input  token_t           tok_in,
    output token_t           tok_out
);

    logic [ADDR_W-1:0] entry_reg;
    token_t            tok_reg, tok_next;
    logic              in_use;
    logic              match;

    // Only slots below the fill level hold written addresses
    assign in_use = (CNT_W'(cell_index) < bcast.count);
    assign match  = tok_in.valid && in_use && bcast.key_nonzero && (entry_reg == bcast.key);

    // Later slots override earlier ones, so the highest match wins
    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit = 1'b1;
            tok_next.idx = cell_index;
        end
    end

    // Hand the token to the next slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Append the key when this slot is the next free one
    always_ff @(posedge clk)
    begin
        if (bcast.wr_en && (bcast.count == CNT_W'(cell_index)))
        begin
            entry_reg <= bcast.key;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ src/pairing_address_registration.sv @@
// Top level of the pairing address registration block: controller, CRC unit and slot row.
//
// Usage:
//   s_axis carries one pairing request per transaction: check byte and 48-bit address.
//   m_axis returns one result per request: echoed check byte (zero when the CRC fails
//   or the table is full), matched or new slot index (TABLE_DEPTH means full), an
//   added flag and the fill level after the request.
//   The request is checked by a search token that walks the row of TABLE_DEPTH slots,
//   one slot per cycle, while a byte-serial CRC-8 runs beside it.
//   One request is handled at a time: a new request is taken only after the result
//   of the previous one is loaded into the output register.
//   The result sits in an output register; s_axis_tready returns as soon as the
//   result is loaded, so the next request may proceed while the result waits.
//   If the receiver stalls while a second result is ready, the block holds in its
//   final state until the output register is taken.
//   Reset clears the fill level and all control state; slot contents are not cleared
//   and only slots below the fill level are ever compared.
module pairing_address_registration
    import pareg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [7:0] check_byte, [55:8] device_address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [7:0] reply_check, [16:8] tracker_index,
                                        // [17] added, [26:18] entry_total, [31:27] zero
);

    pareg_state_t       state_reg, state_next;
    logic [ADDR_W-1:0]  key_reg;
    logic [CHECK_W-1:0] check_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               inject_reg;
    logic               searched_reg, searched_next;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;

    logic               out_valid_reg, out_valid_next;
    logic [CHECK_W-1:0] out_check_reg;
    logic [OUT_W-1:0]   out_index_reg;
    logic               out_added_reg;
    logic [OUT_W-1:0]   out_total_reg;

    logic               accept;
    logic               finish;
    logic               crc_ok;
    logic               has_room;
    logic               do_add;
    logic [CNT_W-1:0]   result_index;
    logic [7:0]         crc_value;
    logic               crc_done;
    bcast_t             bcast;
    token_t             tok [0:TABLE_DEPTH];

    assign accept = s_axis_tvalid && s_axis_tready;

    // CRC unit
    pareg_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .addr  (s_axis_tdata[55:8]),
        .crc   (crc_value),
        .done  (crc_done)
    );

    // Result of the request
    assign crc_ok       = (crc_value == check_reg);
    assign has_room     = (count_reg < CNT_W'(TABLE_DEPTH));
    assign result_index = found_reg ? CNT_W'(found_idx_reg) : count_reg;
    assign do_add       = crc_ok && (key_reg != '0) && !found_reg && has_room;

    // Broadcast to the slot row
    assign bcast.key         = key_reg;
    assign bcast.key_nonzero = (key_reg != '0);
    assign bcast.count       = count_reg;
    assign bcast.wr_en       = finish && do_add;

    // Token enters at slot zero
    assign tok[0] = '{valid: inject_reg, hit: 1'b0, idx: '0};

    // Slot row
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        pareg_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .bcast      (bcast),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    // Sequencing and handshake
    always_comb
    begin
        state_next     = state_reg;
        s_axis_tready  = 1'b0;
        finish         = 1'b0;
        searched_next  = searched_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    searched_next = 1'b0;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tok[TABLE_DEPTH].valid)
                begin
                    searched_next = 1'b1;
                end
                if (searched_reg && crc_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    finish         = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = do_add ? count_reg + 1'b1 : count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            inject_reg    <= 1'b0;
            searched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            inject_reg    <= accept;
            searched_reg  <= searched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and search payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            check_reg <= s_axis_tdata[7:0];
            key_reg   <= s_axis_tdata[55:8];
        end
        if (tok[TABLE_DEPTH].valid)
        begin
            found_reg     <= tok[TABLE_DEPTH].hit;
            found_idx_reg <= tok[TABLE_DEPTH].idx;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_check_reg <= (crc_ok && (found_reg || has_room)) ? check_reg : '0;
            out_index_reg <= OUT_W'(result_index);
            out_added_reg <= do_add;
            out_total_reg <= OUT_W'(do_add ? count_reg + 1'b1 : count_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_total_reg, out_added_reg, out_index_reg, out_check_reg};

    // Fill level never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill level beyond table size");

    // A token leaves the row only during a search
    a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok[TABLE_DEPTH].valid |-> (state_reg == ST_SEARCH))
        else $error("search token outside search");

    // An appended address gets the slot just below the new fill level
    a_added_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[17]) |->
            (m_axis_tdata[26:18] == m_axis_tdata[16:8] + 9'd1))
        else $error("added slot does not match fill level");

    // A writeback bumps the fill level only when an address is added
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (count_reg == $past(count_reg) + CNT_W'($past(do_add))))
        else $error("fill level step mismatch");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the pairing address registration block.
`timescale 1ns / 1ps

module tb;
    import pareg_pkg::*;

    // Run length and the cycle limit, sized for every request waiting out the
    // longest sender gap, the longest receiver stall and the full slot walk
    localparam int N_RANDOM    = 1385;
    localparam int CYCLE_LIMIT = (N_RANDOM + 32) * (TABLE_DEPTH + 4 + 300 + 300) * 4;

    // Request as it sits on s_axis_tdata, check byte in the low bits
    typedef struct packed {
        logic [ADDR_W-1:0]  device_address;
        logic [CHECK_W-1:0] check_byte;
    } request_t;

    typedef struct packed {
        logic [CHECK_W-1:0] reply_check;
        logic [OUT_W-1:0]   tracker_index;
        logic               added;
        logic [OUT_W-1:0]   entry_total;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Stimulus and scoreboard storage
    request_t          pending_req[$];
    reply_t            pending_reply[$];
    logic [ADDR_W-1:0] seen_addr[$];

    // Shadow copy of the pairing table
    logic [ADDR_W-1:0] paired_addr[TABLE_DEPTH];
    int unsigned       table_fill = 0;

    // Bookkeeping
    int unsigned req_total      = 0;
    int unsigned accepted_count = 0;
    int unsigned reply_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned n_appended     = 0;
    int unsigned n_matched      = 0;
    int unsigned n_bad_checksum = 0;
    int unsigned n_table_full   = 0;
    int unsigned n_zero_addr    = 0;

    // Handshake helpers
    logic        req_taken  = 1'b0;
    int          send_gap   = 0;
    int          stall_left = 0;
    logic        calm_tx    = 1'b0;
    logic        calm_rx    = 1'b0;
    reply_t      want_reply;

    pairing_address_registration i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // CRC-8 over the address bytes, low byte first, one bit per step
    function automatic logic [7:0] addr_crc8(input logic [ADDR_W-1:0] addr);
        logic [7:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < ADDR_W / 8; i++)
        begin
            crc = crc ^ addr[8*i +: 8];
            for (int b = 0; b < 8; b++)
            begin
                crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // Check byte a device must send for this address
    function automatic logic [7:0] pairing_check(input logic [ADDR_W-1:0] addr);
        logic [7:0] crc;
        crc = addr_crc8(addr);
        return (crc == 8'h00) ? CRC_ZERO_SUB : crc;
    endfunction

    // Look up and possibly append one address; return the reply it earns
    function automatic reply_t register_request(input request_t req);
        reply_t      r;
        int unsigned fill;
        int unsigned slot;
        logic        checksum_ok;
        logic        addr_nonzero;
        fill         = (table_fill > TABLE_DEPTH) ? TABLE_DEPTH : table_fill;
        slot         = fill;
        addr_nonzero = (req.device_address != '0);
        if (addr_nonzero)
        begin
            for (int i = 0; i < fill; i++)
            begin
                if (paired_addr[i] == req.device_address)
                begin
                    slot = i;
                end
            end
        end
        checksum_ok = (pairing_check(req.device_address) == req.check_byte);

        // Tally the case this request falls into
        if (!addr_nonzero)
        begin
            n_zero_addr++;
        end
        else if (slot < fill)
        begin
            n_matched++;
        end
        if (!checksum_ok)
        begin
            n_bad_checksum++;
        end
        else if (addr_nonzero && slot == fill && fill >= TABLE_DEPTH)
        begin
            n_table_full++;
        end

        // Append a new, well-formed address while there is room
        r.added = 1'b0;
        if (checksum_ok && addr_nonzero && slot == fill && fill < TABLE_DEPTH)
        begin
            paired_addr[fill] = req.device_address;
            fill++;
            r.added = 1'b1;
            n_appended++;
        end
        table_fill      = fill;
        r.reply_check   = (checksum_ok && slot < TABLE_DEPTH) ? req.check_byte : '0;
        r.tracker_index = OUT_W'(slot);
        r.entry_total   = OUT_W'(fill);
        return r;
    endfunction

    // Idle span for either side: mostly short, now and then long
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 90)
        begin
            return $urandom_range(4, 24);
        end
        return $urandom_range(60, 300);
    endfunction

    task automatic queue_request(input logic [ADDR_W-1:0] addr, input logic [7:0] check);
        request_t req;
        req.device_address = addr;
        req.check_byte     = check;
        pending_req.push_back(req);
        seen_addr.push_back(addr);
        req_total++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Reset, released on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Drive requests at the falling edge; hold until the transaction completes
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken || !s_axis_tvalid)
            begin
                if (send_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (pending_req.size() != 0)
                begin
                    s_axis_tdata  <= pending_req.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                    begin
                        calm_tx <= !calm_tx;
                    end
                    send_gap <= (calm_tx || $urandom_range(0, 99) < 40) ? 0 : idle_span();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure with calm stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 999) == 0)
                begin
                    calm_rx <= !calm_rx;
                end
                if (!calm_rx && $urandom_range(0, 49) == 0)
                begin
                    stall_left <= idle_span();
                end
            end
        end
    end

    // Monitor: predict on each request transaction, compare on each result transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_reply.push_back(register_request(request_t'(s_axis_tdata)));
                accepted_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                reply_count++;
                if (pending_reply.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want_reply = pending_reply.pop_front();
                    check_field("reply_check", want_reply.reply_check, m_axis_tdata[7:0]);
                    check_field("tracker_index", want_reply.tracker_index,
                                m_axis_tdata[16:8]);
                    check_field("added", want_reply.added, m_axis_tdata[17]);
                    check_field("entry_total", want_reply.entry_total, m_axis_tdata[26:18]);
                    check_field("padding", 0, m_axis_tdata[31:27]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_reply.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] zero_crc_addr;
        int                roll;

        // Find an address whose raw CRC is zero
        zero_crc_addr = 48'd1;
        while (addr_crc8(zero_crc_addr) != 8'h00 && zero_crc_addr < 48'd1000000)
        begin
            zero_crc_addr++;
        end

        // Directed: zero address on an empty table
        queue_request('0, pairing_check('0));
        queue_request('0, 8'h00);
        // All-ones address: append, hit, then hit with a bad checksum
        queue_request('1, pairing_check('1));
        queue_request('1, pairing_check('1));
        queue_request('1, pairing_check('1) ^ 8'hFF);
        // Address whose CRC is zero: check byte 8 is the valid one
        queue_request(zero_crc_addr, CRC_ZERO_SUB);
        queue_request(zero_crc_addr, 8'h00);
        // Single-bit and alternating patterns, extreme check bytes
        queue_request(48'd1, 8'hFF);
        queue_request(48'd1, pairing_check(48'd1));
        queue_request(48'h8000_0000_0000, pairing_check(48'h8000_0000_0000));
        queue_request(48'hAAAA_AAAA_AAAA, pairing_check(48'hAAAA_AAAA_AAAA));
        queue_request(48'h5555_5555_5555, pairing_check(48'h5555_5555_5555));
        // Refused on checksum, then accepted
        addr = {16'($urandom), 32'($urandom)} | 48'd2;
        queue_request(addr, pairing_check(addr) ^ 8'h01);
        queue_request(addr, pairing_check(addr));
        // Zero address once the table holds entries
        queue_request('0, pairing_check('0));
        queue_request('0, 8'hFF);

        // Random: mostly well-formed new pairings and repeats, some noise
        for (int n = 0; n < N_RANDOM; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                addr = {16'($urandom), 32'($urandom)};
                if (addr == '0)
                begin
                    addr = 48'd3;
                end
                queue_request(addr, pairing_check(addr));
            end
            else if (roll < 65)
            begin
                addr = seen_addr[$urandom_range(0, seen_addr.size() - 1)];
                queue_request(addr, pairing_check(addr));
            end
            else if (roll < 75)
            begin
                addr = seen_addr[$urandom_range(0, seen_addr.size() - 1)];
                queue_request(addr, pairing_check(addr) ^ 8'($urandom_range(1, 255)));
            end
            else if (roll < 87)
            begin
                queue_request({16'($urandom), 32'($urandom)}, 8'($urandom));
            end
            else if (roll < 92)
            begin
                queue_request('0, ($urandom_range(0, 1) == 0) ? pairing_check('0)
                                                               : 8'($urandom));
            end
            else
            begin
                // Sparse or dense patterns with a valid checksum
                addr = 48'd1 << $urandom_range(0, ADDR_W - 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    addr = ~addr;
                end
                queue_request(addr, pairing_check(addr));
            end
        end

        // Drain: every request taken and every result checked
        @(posedge rst_n);
        while (accepted_count < req_total || pending_reply.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Ran %0d requests (%0d results): %0d appended, %0d matched, %0d zero addresses",
                 accepted_count, reply_count, n_appended, n_matched, n_zero_addr);
        $display("Checksum refusals %0d, full-table refusals %0d, final fill %0d of %0d",
                 n_bad_checksum, n_table_full, table_fill, TABLE_DEPTH);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ pairing_address_registration.f @@
src/pareg_pkg.sv
src/pareg_crc.sv
src/pareg_cell.sv
src/pairing_address_registration.sv
dv/tb.sv
